@@ design/rba_pkg.sv @@
// Shared types and constants for the reference-counted block allocator.
// Holds request and status codes, the configuration register map and the
// command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package rba_pkg;

  // Parameter defaults
  localparam int unsigned POOL_BLOCKS_DEF = 1024;
  localparam int unsigned REF_BITS_DEF    = 16;

  // Configuration port
  localparam int unsigned CFG_W     = 11;
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL0_SIZE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_POOL1_SIZE = 1'b1;
  localparam logic [CFG_W-1:0]     SIZE_RESET     = 11'd1024;

  // Request codes
  localparam logic [1:0] REQ_ALLOC   = 2'd0;
  localparam logic [1:0] REQ_RELEASE = 2'd1;
  localparam logic [1:0] REQ_RETAIN  = 2'd2;
  localparam logic [1:0] REQ_COW     = 2'd3;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_NOFREE  = 3'd1;
  localparam logic [2:0] ST_RANGE   = 3'd2;
  localparam logic [2:0] ST_NOTUSED = 3'd3;
  localparam logic [2:0] ST_MAX     = 3'd4;

  // Controller to datapath
  typedef struct packed {
    logic capture;  // latch the request beat and launch memory reads
    logic exec;     // commit the step and load the result register
    logic fix;      // second count write of a copy that took a new block
  } rba_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic fix_needed;  // current step needs the second count write
  } rba_stat_t;

endpackage

@@ design/refcounted_block_allocator.sv @@
// Top level of the reference-counted block allocator: joins the controller
// and the datapath. Depends on rba_pkg, rba_ctrl and rba_dp.
//
// Two pools of POOL_BLOCKS blocks, each with a REF_BITS reference count per
// block and a last-in first-out stack of freed blocks; never-used blocks are
// issued in ascending order by a fresh counter after the stack runs empty.
// The accept edge launches the count and stack-top reads from the
// single-port memories; the execute step, held while the output is blocked,
// updates counts, stack and counters and loads the result register. A copy
// request that takes a new block adds a fix step, since its two count writes
// share the count memory's one write port. One request is in flight at a
// time; a new request is taken while the previous result still waits at the
// output. Counts need no clearing pass after reset: a block at or above the
// fresh counter reads as zero. Write the size registers only while idle.
`timescale 1ns / 1ps

module refcounted_block_allocator #(
  parameter int unsigned POOL_BLOCKS = rba_pkg::POOL_BLOCKS_DEF,
  parameter int unsigned REF_BITS    = rba_pkg::REF_BITS_DEF,
  parameter int unsigned IDX_W       = $clog2(POOL_BLOCKS),
  parameter int unsigned CNT_W       = $clog2(POOL_BLOCKS + 1)
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [rba_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [rba_pkg::CFG_W-1:0]     cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [1:0]                    req_type_i,
  input  logic                          pool_i,
  input  logic [IDX_W-1:0]              block_index_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [2:0]                    status_o,
  output logic [IDX_W-1:0]              result_block_o,
  output logic                          copy_needed_o,
  output logic [CNT_W-1:0]              free_count_o,
  output logic [REF_BITS-1:0]           ref_after_o
);
  import rba_pkg::*;

  rba_cmd_t  cmd;
  rba_stat_t stat;

  rba_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  rba_dp #(
    .POOL_BLOCKS(POOL_BLOCKS),
    .REF_BITS   (REF_BITS),
    .IDX_W      (IDX_W),
    .CNT_W      (CNT_W)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .stat_o        (stat),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .req_type_i    (req_type_i),
    .pool_i        (pool_i),
    .block_index_i (block_index_i),
    .status_o      (status_o),
    .result_block_o(result_block_o),
    .copy_needed_o (copy_needed_o),
    .free_count_o  (free_count_o),
    .ref_after_o   (ref_after_o)
  );

endmodule

@@ design/rba_ctrl.sv @@
// Controller for the block allocator: sequences capture, execute and the
// optional second count write, and owns the result valid flag. Uses rba_pkg.
`timescale 1ns / 1ps

module rba_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  input  rba_pkg::rba_stat_t stat_i,
  output rba_pkg::rba_cmd_t  cmd_o
);
  import rba_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_EXEC = 2'd1;
  localparam logic [1:0] S_FIX  = 2'd2;

  logic [1:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  // Next state and commands
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_EXEC;
        end
      end
      S_EXEC: begin
        // hold until the result register can take the beat
        if (out_free) begin
          cmd_o.exec = 1'b1;
          state_d    = stat_i.fix_needed ? S_FIX : S_IDLE;
        end
      end
      S_FIX: begin
        cmd_o.fix = 1'b1;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Result valid: set on commit, drop when the beat is taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.exec) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

endmodule

@@ design/rba_dp.sv @@
// Datapath for the block allocator: count and free-stack memories for both
// pools, stack depth and fresh counters, size registers and result register.
// Uses rba_pkg; driven by rba_ctrl commands.
`timescale 1ns / 1ps

module rba_dp #(
  parameter int unsigned POOL_BLOCKS = rba_pkg::POOL_BLOCKS_DEF,
  parameter int unsigned REF_BITS    = rba_pkg::REF_BITS_DEF,
  parameter int unsigned IDX_W       = $clog2(POOL_BLOCKS),
  parameter int unsigned CNT_W       = $clog2(POOL_BLOCKS + 1)
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  rba_pkg::rba_cmd_t               cmd_i,
  output rba_pkg::rba_stat_t              stat_o,
  input  logic                            cfg_we_i,
  input  logic [rba_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [rba_pkg::CFG_W-1:0]       cfg_wdata_i,
  input  logic [1:0]                      req_type_i,
  input  logic                            pool_i,
  input  logic [IDX_W-1:0]                block_index_i,
  output logic [2:0]                      status_o,
  output logic [IDX_W-1:0]                result_block_o,
  output logic                            copy_needed_o,
  output logic [CNT_W-1:0]                free_count_o,
  output logic [REF_BITS-1:0]             ref_after_o
);
  import rba_pkg::*;

  localparam int unsigned MEM_DEPTH = 2 * (1 << IDX_W);
  localparam int unsigned EW        = (CFG_W > CNT_W) ? CFG_W : CNT_W;
  localparam logic [EW-1:0]       POOL_BLOCKS_E = EW'(POOL_BLOCKS);
  localparam logic [CNT_W-1:0]    POOL_BLOCKS_C = CNT_W'(POOL_BLOCKS);
  localparam logic [REF_BITS-1:0] REF_MAX       = {REF_BITS{1'b1}};
  localparam logic [REF_BITS-1:0] REF_ONE       = REF_BITS'(1);

  // Memories: address is {pool, block}
  logic [REF_BITS-1:0] cnt_mem   [MEM_DEPTH];
  logic [IDX_W-1:0]    stack_mem [MEM_DEPTH];

  // Per-pool control state
  logic [CFG_W-1:0] size_q  [2];
  logic [CNT_W-1:0] depth_q [2];
  logic [CNT_W-1:0] fresh_q [2];
  logic [CNT_W-1:0] eff_size [2];

  // Captured request and registered read data
  logic [1:0]          req_q;
  logic                pool_q;
  logic [IDX_W-1:0]    idx_q;
  logic [REF_BITS-1:0] cnt_rd_q;
  logic [IDX_W-1:0]    top_rd_q;
  logic [CNT_W-1:0]    top_addr;

  // Result register
  logic [2:0]          status_q,  status_d;
  logic [IDX_W-1:0]    result_q,  result_d;
  logic                copy_q,    copy_d;
  logic [CNT_W-1:0]    free_q,    free_d;
  logic [REF_BITS-1:0] after_q,   after_d;

  // Step logic
  logic [CNT_W-1:0]    depth_sel, fresh_sel, eff_sel, depth_d, fresh_d;
  logic [CNT_W-1:0]    idx_ext;
  logic [REF_BITS-1:0] cnt;
  logic                take_ok, in_range, fix_needed;
  logic [IDX_W-1:0]    take_blk;
  logic                cnt_we, stk_we;
  logic [IDX_W:0]      cnt_waddr, stk_waddr;
  logic [REF_BITS-1:0] cnt_wdata;
  logic [IDX_W-1:0]    stk_wdata;

  // Effective size: register clipped to the pool capacity
  always_comb begin
    for (int p = 0; p < 2; p++) begin
      eff_size[p] = (EW'(size_q[p]) > POOL_BLOCKS_E) ? POOL_BLOCKS_C
                                                      : CNT_W'(size_q[p]);
    end
  end

  assign depth_sel = depth_q[pool_q];
  assign fresh_sel = fresh_q[pool_q];
  assign eff_sel   = eff_size[pool_q];
  assign idx_ext   = CNT_W'(idx_q);
  // blocks at or above the fresh counter were never written and read as zero
  assign cnt       = (idx_ext < fresh_sel) ? cnt_rd_q : '0;
  assign take_ok   = (depth_sel != '0) || (fresh_sel < eff_sel);
  assign take_blk  = (depth_sel != '0) ? top_rd_q : fresh_sel[IDX_W-1:0];
  assign in_range  = idx_ext < eff_sel;

  // Decode the request against the read count and the free pool
  always_comb begin
    status_d   = ST_OK;
    result_d   = '0;
    copy_d     = 1'b0;
    after_d    = '0;
    depth_d    = depth_sel;
    fresh_d    = fresh_sel;
    cnt_we     = 1'b0;
    cnt_waddr  = {pool_q, idx_q};
    cnt_wdata  = '0;
    stk_we     = 1'b0;
    stk_waddr  = {pool_q, depth_sel[IDX_W-1:0]};
    stk_wdata  = idx_q;
    fix_needed = 1'b0;
    if (req_q == REQ_ALLOC) begin
      if (take_ok) begin
        cnt_we    = 1'b1;
        cnt_waddr = {pool_q, take_blk};
        cnt_wdata = REF_ONE;
        result_d  = take_blk;
        after_d   = REF_ONE;
        if (depth_sel != '0) begin
          depth_d = depth_sel - CNT_W'(1);
        end else begin
          fresh_d = fresh_sel + CNT_W'(1);
        end
      end else begin
        status_d = ST_NOFREE;
      end
    end else if (!in_range) begin
      status_d = ST_RANGE;
    end else if (cnt == '0) begin
      status_d = ST_NOTUSED;
    end else begin
      case (req_q)
        REQ_RELEASE: begin
          cnt_we    = 1'b1;
          cnt_wdata = cnt - REF_ONE;
          after_d   = cnt - REF_ONE;
          // push the block once its last owner lets go
          if ((cnt == REF_ONE) && (depth_sel < POOL_BLOCKS_C)) begin
            stk_we  = 1'b1;
            depth_d = depth_sel + CNT_W'(1);
          end
        end
        REQ_RETAIN: begin
          if (cnt == REF_MAX) begin
            status_d = ST_MAX;
            after_d  = cnt;
          end else begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt + REF_ONE;
            after_d   = cnt + REF_ONE;
          end
        end
        REQ_COW: begin
          if (cnt == REF_ONE) begin
            result_d = idx_q;
            after_d  = REF_ONE;
          end else if (take_ok) begin
            // new block now, source decrement in the next cycle
            cnt_we     = 1'b1;
            cnt_waddr  = {pool_q, take_blk};
            cnt_wdata  = REF_ONE;
            result_d   = take_blk;
            copy_d     = 1'b1;
            after_d    = REF_ONE;
            fix_needed = 1'b1;
            if (depth_sel != '0) begin
              depth_d = depth_sel - CNT_W'(1);
            end else begin
              fresh_d = fresh_sel + CNT_W'(1);
            end
          end else begin
            status_d = ST_NOFREE;
            after_d  = cnt;
          end
        end
        default: status_d = ST_OK;
      endcase
    end
    // free blocks left after the step
    free_d = depth_d + ((eff_sel > fresh_d) ? (eff_sel - fresh_d) : '0);
    // source count write of a copy
    if (cmd_i.fix) begin
      cnt_we    = 1'b1;
      cnt_waddr = {pool_q, idx_q};
      cnt_wdata = cnt_rd_q - REF_ONE;
    end
  end

  assign stat_o.fix_needed = fix_needed;
  assign top_addr          = depth_q[pool_i] - CNT_W'(1);

  // Count memory: one write, one registered read
  always_ff @(posedge clk_i) begin
    if (cnt_we && (cmd_i.exec || cmd_i.fix)) begin
      cnt_mem[cnt_waddr] <= cnt_wdata;
    end
    if (cmd_i.capture) begin
      cnt_rd_q <= cnt_mem[{pool_i, block_index_i}];
    end
  end

  // Free stack memory: push on release, read the top on capture
  always_ff @(posedge clk_i) begin
    if (stk_we && cmd_i.exec) begin
      stack_mem[stk_waddr] <= stk_wdata;
    end
    if (cmd_i.capture) begin
      top_rd_q <= stack_mem[{pool_i, top_addr[IDX_W-1:0]}];
    end
  end

  // Request capture and result register
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      req_q  <= req_type_i;
      pool_q <= pool_i;
      idx_q  <= block_index_i;
    end
    if (cmd_i.exec) begin
      status_q <= status_d;
      result_q <= result_d;
      copy_q   <= copy_d;
      free_q   <= free_d;
      after_q  <= after_d;
    end
  end

  // Pool counters and size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int p = 0; p < 2; p++) begin
        size_q[p]  <= SIZE_RESET;
        depth_q[p] <= '0;
        fresh_q[p] <= '0;
      end
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CFG_POOL0_SIZE) begin
          size_q[0] <= cfg_wdata_i;
        end
        if (cfg_index_i == CFG_POOL1_SIZE) begin
          size_q[1] <= cfg_wdata_i;
        end
      end
      if (cmd_i.exec) begin
        depth_q[pool_q] <= depth_d;
        fresh_q[pool_q] <= fresh_d;
      end
    end
  end

  assign status_o       = status_q;
  assign result_block_o = result_q;
  assign copy_needed_o  = copy_q;
  assign free_count_o   = free_q;
  assign ref_after_o    = after_q;

endmodule
